### hw/rtl/pso_pkg.sv
// Shared types and constants for the polyline stroke offset block.
package pso_pkg;

  localparam int CW       = 16;
  localparam int DW       = 17;
  localparam int RW       = 12;
  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = 2;
  localparam logic [1:0] MIN_SEEN = 2'd2;
  localparam logic [1:0] FULL_SEEN = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic                 last;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SQ, B_SUM, B_SQRT, B_MUL, B_DINIT, B_DIV, B_OUT
  } back_state_t;

endpackage

### hw/rtl/pso_front.sv
// Front end: takes points, keeps the last two, and issues up to three offset jobs per point.
module pso_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [pso_pkg::CW-1:0] point_x,
  input  logic signed [pso_pkg::CW-1:0] point_y,
  input  logic                         point_is_last,
  output logic                         job_valid,
  output pso_pkg::job_t                job,
  input  logic                         job_full
);
  import pso_pkg::*;

  logic signed [CW-1:0] held_x [2];
  logic signed [CW-1:0] held_y [2];
  logic [1:0]           points_seen;
  job_t                 pend [3];
  logic [1:0]           pend_cnt;
  logic [1:0]           rd;
  logic                 accept;
  job_t                 j_first, j_inner, j_last;

  function automatic logic signed [DW-1:0] diff(input logic signed [CW-1:0] b,
                                               input logic signed [CW-1:0] a);
    diff = {b[CW-1], b} - {a[CW-1], a};
  endfunction

  assign full      = (pend_cnt != 2'd0);
  assign accept    = push && !full;
  assign job_valid = (pend_cnt != 2'd0);
  assign job       = pend[rd];

  always_comb begin
    j_first = '{px: held_x[0], py: held_y[0], dx: diff(held_x[1], held_x[0]),
                dy: diff(held_y[1], held_y[0]), last: 1'b0};
    j_inner = '{px: held_x[1], py: held_y[1], dx: diff(point_x, held_x[0]),
                dy: diff(point_y, held_y[0]), last: 1'b0};
    j_last  = '{px: point_x, py: point_y, dx: diff(point_x, held_x[1]),
                dy: diff(point_y, held_y[1]), last: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= 2'd0;
      pend_cnt    <= 2'd0;
      rd          <= 2'd0;
      held_x[0]   <= '0;
      held_x[1]   <= '0;
      held_y[0]   <= '0;
      held_y[1]   <= '0;
    end else if (accept) begin
      rd <= 2'd0;
      if (points_seen < MIN_SEEN) begin
        held_x[points_seen[0]] <= point_x;
        held_y[points_seen[0]] <= point_y;
        points_seen <= point_is_last ? 2'd0 : points_seen + 2'd1;
      end else begin
        if (points_seen == MIN_SEEN) begin
          pend[0]  <= j_first;
          pend[1]  <= j_inner;
          pend[2]  <= j_last;
          pend_cnt <= point_is_last ? 2'd3 : 2'd2;
        end else begin
          pend[0]  <= j_inner;
          pend[1]  <= j_last;
          pend_cnt <= point_is_last ? 2'd2 : 2'd1;
        end
        points_seen <= point_is_last ? 2'd0 : FULL_SEEN;
        held_x[0] <= held_x[1];
        held_y[0] <= held_y[1];
        held_x[1] <= point_x;
        held_y[1] <= point_y;
      end
    end else if (job_valid && !job_full) begin
      rd       <= rd + 2'd1;
      pend_cnt <= pend_cnt - 2'd1;
    end
  end

endmodule

### hw/rtl/pso_jq.sv
// Short job queue between the front end and the offset unit.
module pso_jq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  pso_pkg::job_t wdata,
  output logic          full,
  input  logic          rd,
  output pso_pkg::job_t rdata,
  output logic          empty
);
  import pso_pkg::*;

  job_t             mem [JQ_DEPTH];
  logic [JQ_AW-1:0] wp, rp;
  logic [JQ_AW:0]   count;
  logic             do_wr, do_rd;

  assign full  = (count == (JQ_AW+1)'(JQ_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= wp + 1'b1;
      if (do_rd) rp <= rp + 1'b1;
      count <= count + (JQ_AW+1)'(do_wr) - (JQ_AW+1)'(do_rd);
    end
  end

endmodule

### hw/rtl/pso_back.sv
// Offset unit: squares, iterative square root, two restoring divides, saturating vertex output.
module pso_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pso_pkg::RW-1:0]        radius,
  input  logic                          q_empty,
  input  pso_pkg::job_t                 q_data,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [pso_pkg::CW-1:0] left_x,
  output logic signed [pso_pkg::CW-1:0] left_y,
  output logic signed [pso_pkg::CW-1:0] right_x,
  output logic signed [pso_pkg::CW-1:0] right_y,
  output logic                          strip_end
);
  import pso_pkg::*;

  back_state_t state, state_next;
  job_t        job;
  logic [32:0] sqx, sqy;
  logic [33:0] s_sum;
  logic        zero_dir;
  logic [49:0] rem_s;
  logic [50:0] root;
  logic [49:0] bsel;
  logic [4:0]  cnt;
  logic [50:0] trial;
  logic        sq_ge;
  logic [24:0] h;
  logic [27:0] prodx, prody;
  logic [16:0] absx, absy;
  logic [36:0] remx, remy;
  logic [35:0] dsh;
  logic [11:0] qx, qy;
  logic        out_valid;
  logic        slot_free;
  logic signed [12:0] co, si;

  function automatic logic signed [CW-1:0] sat16(input logic signed [CW:0] v);
    if (v > 17'sd32767) sat16 = 16'sh7FFF;
    else if (v < -17'sd32768) sat16 = 16'sh8000;
    else sat16 = v[CW-1:0];
  endfunction

  assign s_sum     = {1'b0, sqx} + {1'b0, sqy};
  assign trial     = root + {1'b0, bsel};
  assign sq_ge     = {1'b0, rem_s} >= trial;
  assign h         = root[24:0];
  assign absx      = job.dx[DW-1] ? -job.dx : job.dx;
  assign absy      = job.dy[DW-1] ? -job.dy : job.dy;
  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;
  assign co = zero_dir ? 13'sd0 : (job.dx[DW-1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
  assign si = zero_dir ? 13'sd0 : (job.dy[DW-1] ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = B_SQ;
        end
      end
      B_SQ:    state_next = B_SUM;
      B_SUM:   state_next = (s_sum == '0) ? B_OUT : B_SQRT;
      B_SQRT:  if (cnt == '0) state_next = B_MUL;
      B_MUL:   state_next = B_DINIT;
      B_DINIT: state_next = B_DIV;
      B_DIV:   if (cnt == '0) state_next = B_OUT;
      B_OUT:   if (slot_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE:  if (!q_empty) job <= q_data;
      B_SQ: begin
        sqx <= 33'($signed(job.dx) * $signed(job.dx));
        sqy <= 33'($signed(job.dy) * $signed(job.dy));
      end
      B_SUM: begin
        zero_dir <= (s_sum == '0);
        rem_s    <= {s_sum[33:0], 16'b0};
        root     <= '0;
        bsel     <= 50'(1) << 48;
        cnt      <= 5'd24;
      end
      B_SQRT: begin
        if (sq_ge) begin
          rem_s <= rem_s - trial[49:0];
          root  <= (root >> 1) + {1'b0, bsel};
        end else begin
          root <= root >> 1;
        end
        bsel <= bsel >> 2;
        cnt  <= cnt - 5'd1;
      end
      B_MUL: begin
        prodx <= radius * absx[15:0];
        prody <= radius * absy[15:0];
      end
      B_DINIT: begin
        remx <= {1'b0, prodx, 8'b0} + {13'b0, h[24:1]};
        remy <= {1'b0, prody, 8'b0} + {13'b0, h[24:1]};
        dsh  <= {h, 11'b0};
        cnt  <= 5'd11;
      end
      B_DIV: begin
        if (remx >= {1'b0, dsh}) begin
          remx <= remx - {1'b0, dsh};
          qx   <= {qx[10:0], 1'b1};
        end else begin
          qx <= {qx[10:0], 1'b0};
        end
        if (remy >= {1'b0, dsh}) begin
          remy <= remy - {1'b0, dsh};
          qy   <= {qy[10:0], 1'b1};
        end else begin
          qy <= {qy[10:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && slot_free) begin
      left_x    <= sat16({job.px[CW-1], job.px} + {{4{si[12]}}, si});
      left_y    <= sat16({job.py[CW-1], job.py} - {{4{co[12]}}, co});
      right_x   <= sat16({job.px[CW-1], job.px} - {{4{si[12]}}, si});
      right_y   <= sat16({job.py[CW-1], job.py} + {{4{co[12]}}, co});
      strip_end <= job.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == B_OUT && slot_free) out_valid <= 1'b1;
    else if (pop) out_valid <= 1'b0;
  end

`ifndef SYNTH
  a_qx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && !zero_dir) |-> (qx <= radius))
    else $error("x quotient exceeds radius");
  a_qy_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && !zero_dir) |-> (qy <= radius))
    else $error("y quotient exceeds radius");
  a_root_min: assert property (@(posedge clk) disable iff (rst)
    (state == B_MUL) |-> (h >= 25'd256))
    else $error("square root too small for nonzero direction");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == B_OUT))
    else $error("result word appeared without a finished job");
`endif

endmodule

### hw/rtl/polyline_stroke_offset.sv
// Top level of the polyline stroke offset block.
// Usage:
//   Points enter on point_x/point_y/point_is_last; a word is taken when push
//   is high and full is low. Results leave as vertex pairs on left_*/right_*
//   and strip_end; the oldest word is valid while empty is low and is taken
//   when pop is high.
//   stroke_radius is written through cfg_wr_en/cfg_wr_data while idle.
// Flow:
//   A point emits zero to three pairs. The offset unit works on one pair at
//   a time: squares, a 25-step square root and two 12-step divides running
//   side by side; a zero-length direction skips the root and divides. The
//   offset unit sets throughput. The front end takes a new point once its
//   jobs have entered the 4-deep job queue; it stalls when that queue is
//   full.
// Reset:
//   rst clears the held points, counters, queue and output slot; the radius
//   returns to 16 (1.0 in Q8.4).
// Stall:
//   With pop low the output word holds and the offset unit waits after its
//   current job; the queue and front end then fill and full rises.
module polyline_stroke_offset (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [pso_pkg::CW-1:0] point_x,
  input  logic signed [pso_pkg::CW-1:0] point_y,
  input  logic                          point_is_last,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [pso_pkg::CW-1:0] left_x,
  output logic signed [pso_pkg::CW-1:0] left_y,
  output logic signed [pso_pkg::CW-1:0] right_x,
  output logic signed [pso_pkg::CW-1:0] right_y,
  output logic                          strip_end,
  input  logic                          cfg_wr_en,
  input  logic [pso_pkg::RW-1:0]        cfg_wr_data
);
  import pso_pkg::*;

  logic [RW-1:0] stroke_radius;
  logic          f_valid, jq_full, jq_empty, jq_pop;
  job_t          f_job, jq_job;

  always_ff @(posedge clk) begin
    if (rst) stroke_radius <= 12'd16;
    else if (cfg_wr_en) stroke_radius <= cfg_wr_data;
  end

  pso_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .point_x(point_x), .point_y(point_y), .point_is_last(point_is_last),
    .job_valid(f_valid), .job(f_job), .job_full(jq_full)
  );

  pso_jq u_jq (
    .clk(clk), .rst(rst), .wr(f_valid), .wdata(f_job), .full(jq_full),
    .rd(jq_pop), .rdata(jq_job), .empty(jq_empty)
  );

  pso_back u_back (
    .clk(clk), .rst(rst), .radius(stroke_radius),
    .q_empty(jq_empty), .q_data(jq_job), .q_pop(jq_pop),
    .empty(empty), .pop(pop),
    .left_x(left_x), .left_y(left_y), .right_x(right_x), .right_y(right_y),
    .strip_end(strip_end)
  );

endmodule
